/* src/b58_pkg.sv */
// Package for the base-58 identifier encoder.
// Holds shared widths, the divide-by-58 constants, the link type between cells
// and the alphabet lookup. Depends on nothing.
package b58_pkg;

    // Digit and group geometry.
    localparam int RADIX_INT  = 58;
    localparam int DIGIT_W    = 6;
    localparam int GROUP_W    = 4;
    localparam int VALUE_W    = 32;
    localparam int NUM_GROUPS = VALUE_W / GROUP_W;
    localparam int GCNT_W     = $clog2(NUM_GROUPS);
    localparam int NUM_CELLS  = 6;
    localparam int IDX_W      = $clog2(NUM_CELLS);
    localparam int CHAR_W     = 7;

    // A cell works on digit * 16 + carry, which stays below 58 * 16.
    localparam int WORK_W     = DIGIT_W + GROUP_W;

    // Quotient by 58 as a multiply by a scaled reciprocal; exact for WORK_W-bit values.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 11;
    localparam int PROD_W      = WORK_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1130);
    localparam logic [WORK_W-1:0]  RADIX = WORK_W'(RADIX_INT);

    localparam logic [GCNT_W-1:0] LAST_GROUP = GCNT_W'(NUM_GROUPS - 1);
    localparam logic [IDX_W-1:0]  TOP_IDX    = IDX_W'(NUM_CELLS - 1);

    // The alphabet, first character in the top byte.
    localparam logic [8*RADIX_INT-1:0] ALPHABET =
        "123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";

    // What one cell hands to the next in each cycle.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic [GROUP_W-1:0] carry;
    } link_t;

    typedef logic [DIGIT_W-1:0] digit_t;

    // ASCII code of one base-58 digit.
    function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
        logic [8:0] pos;
        pos = 9'(RADIX_INT - 1) - 9'(d);
        if (d > DIGIT_W'(RADIX_INT - 1))
        begin
            return ALPHABET[8*(RADIX_INT-1) +: CHAR_W];
        end
        return ALPHABET[8*pos +: CHAR_W];
    endfunction

endpackage

/* src/base58_uid_encoder_top.sv */
// Top level of the base-58 identifier encoder: group feeder, chain of digit
// cells and output stage. Depends on b58_pkg, b58_cell and b58_emitter.
//
//   channel   valid         stall         payload
//   input     value_valid   value_stall   value[31:0]
//   output    char_valid    char_stall    character[6:0], last
//
// An identifier enters as eight 4-bit groups, one per cycle, and ripples
// through six registered cells; its digits are final once the last group has
// passed the top cell. They then move to the output stage when it is empty, and
// the next identifier can be taken after that move. The output stage sends one
// to six characters, one per cycle while char_stall is low. The input rate is
// set by the group feed, the cell chain depth and the hand-off.
// rst_n clears all control state at once; output stalls hold the finished
// digits in the cells and keep value_stall high.
module base58_uid_encoder_top
    import b58_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               value_valid,
    output logic               value_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               char_valid,
    input  logic               char_stall,
    output logic [CHAR_W-1:0]  character,
    output logic               last
);

    logic [VALUE_W-1:0] shift_reg;
    logic [GCNT_W-1:0]  gcnt_reg;
    logic               feeding_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               accept;
    logic               capture;
    logic               empty;
    link_t              links [NUM_CELLS+1];
    digit_t             digits [NUM_CELLS];

    assign accept      = value_valid && !value_stall;
    assign value_stall = busy_reg;
    assign capture     = done_reg && empty;

    // Group feeder: top nibble first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feeding_reg <= 1'b0;
            gcnt_reg    <= '0;
        end
        else if (accept)
        begin
            feeding_reg <= 1'b1;
            gcnt_reg    <= '0;
        end
        else if (feeding_reg)
        begin
            gcnt_reg <= gcnt_reg + 1'b1;
            if (gcnt_reg == LAST_GROUP)
            begin
                feeding_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg <= value;
        end
        else if (feeding_reg)
        begin
            shift_reg <= shift_reg << GROUP_W;
        end
    end

    always_comb
    begin
        links[0].valid = feeding_reg;
        links[0].first = (gcnt_reg == '0);
        links[0].last  = (gcnt_reg == LAST_GROUP);
        links[0].carry = shift_reg[VALUE_W-1 -: GROUP_W];
    end

    // Chain of digit cells, least significant digit in cell zero.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        b58_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[k]),
            .link_out (links[k+1]),
            .digit    (digits[k])
        );
    end

    // Busy from accept until the digits move to the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (capture)
            begin
                busy_reg <= 1'b0;
            end
            if (links[NUM_CELLS].valid && links[NUM_CELLS].last)
            begin
                done_reg <= 1'b1;
            end
            else if (capture)
            begin
                done_reg <= 1'b0;
            end
        end
    end

    b58_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (capture),
        .digits     (digits),
        .empty      (empty),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .last       (last)
    );

endmodule

/* src/b58_cell.sv */
// One cell of the base-58 conversion chain: holds one digit.
// Each beat multiplies the digit by 16, adds the incoming carry and passes
// the quotient by 58 on to the next cell. Depends on b58_pkg.
module b58_cell
    import b58_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  link_t  link_in,
    output link_t  link_out,
    output digit_t digit
);

    digit_t             digit_reg;
    digit_t             digit_next;
    link_t              link_reg;
    link_t              link_next;
    logic [WORK_W-1:0]  work;
    logic [PROD_W-1:0]  prod;
    logic [GROUP_W-1:0] quot;
    logic [WORK_W-1:0]  quot_times_radix;

    // Scale the held digit (cleared on the first group) and add the carry.
    always_comb
    begin
        if (link_in.first)
        begin
            work = WORK_W'(link_in.carry);
        end
        else
        begin
            work = {digit_reg, link_in.carry};
        end
        prod             = PROD_W'(work) * PROD_W'(RECIP);
        quot             = prod[RECIP_SHIFT +: GROUP_W];
        quot_times_radix = WORK_W'(quot) * RADIX;
        digit_next       = DIGIT_W'(work - quot_times_radix);
        link_next.valid  = link_in.valid;
        link_next.first  = link_in.first;
        link_next.last   = link_in.last;
        link_next.carry  = quot;
    end

    // The digit and the outgoing first, last and carry change only on a valid beat; valid is registered from link_in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg.valid <= link_in.valid;
            if (link_in.valid)
            begin
                link_reg.first <= link_next.first;
                link_reg.last  <= link_next.last;
                link_reg.carry <= link_next.carry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            digit_reg <= digit_next;
        end
    end

    assign link_out = link_reg;
    assign digit    = digit_reg;

endmodule

/* src/b58_emitter.sv */
// Output stage of the base-58 encoder: holds the finished digits and sends
// them most significant first, skipping leading zeros. Depends on b58_pkg.
module b58_emitter
    import b58_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 capture,
    input  digit_t               digits [NUM_CELLS],
    output logic                 empty,
    output logic                 char_valid,
    input  logic                 char_stall,
    output logic [CHAR_W-1:0]    character,
    output logic                 last
);

    digit_t           digits_reg [NUM_CELLS];
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    logic [IDX_W-1:0] top;
    logic             beat;

    // Highest nonzero digit; digit zero is always sent.
    always_comb
    begin
        top = '0;
        for (int k = 1; k < NUM_CELLS; k++)
        begin
            if (digits[k] != '0)
            begin
                top = IDX_W'(k);
            end
        end
    end

    assign beat = valid_reg && !char_stall;

    // Walk down from the top digit, one beat at a time.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (capture)
        begin
            idx_next   = top;
            valid_next = 1'b1;
        end
        else if (beat)
        begin
            if (idx_reg == '0)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            digits_reg <= digits;
        end
    end

    assign empty      = !valid_reg;
    assign char_valid = valid_reg;
    assign character  = digit_char(digits_reg[idx_reg]);
    assign last       = (idx_reg == '0);

endmodule

/* bench/tb_base58_uid_encoder_top.sv */
// Self-checking bench for base58_uid_encoder_top: drives identifiers, predicts the
// base-58 text of each one and checks every character beat in order.
// Depends on b58_pkg and the encoder RTL.
module tb_base58_uid_encoder_top;
    import b58_pkg::*;

    localparam int NUM_RANDOM   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE       = 20;
    localparam int REPORT_LIMIT = 10;

    // One expected character beat.
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } char_beat_t;

    // Holds the characters still owed by the encoder and compares arrivals.
    class uid_text_scoreboard;
        char_beat_t awaited_chars[$];
        int         mismatches;
        int         ids_noted;
        int         chars_checked;
        int         len_count[7];

        // ASCII of one base-58 digit: 1..9, lower case without l, upper without I and O.
        function logic [CHAR_W-1:0] digit_ascii(input logic [5:0] d);
            int pos;
            if (d < 9)
            begin
                return CHAR_W'(8'h31 + d);
            end
            if (d < 34)
            begin
                pos = d - 9;
                if (pos >= 11)
                begin
                    pos++;
                end
                return CHAR_W'(8'h61 + pos);
            end
            pos = d - 34;
            if (pos >= 8)
            begin
                pos++;
            end
            if (pos >= 14)
            begin
                pos++;
            end
            return CHAR_W'(8'h41 + pos);
        endfunction

        // Splits an accepted identifier into base-58 digits and queues their characters.
        function void note_value(input logic [VALUE_W-1:0] id);
            logic [VALUE_W-1:0] rest;
            logic [5:0]         digits[$];
            char_beat_t         beat;
            rest = id;
            do
            begin
                digits.push_front(6'(rest % 58));
                rest = rest / 58;
            end
            while (rest != 0);
            foreach (digits[i])
            begin
                beat.code = digit_ascii(digits[i]);
                beat.fin  = (i == digits.size() - 1);
                awaited_chars.push_back(beat);
            end
            len_count[digits.size()]++;
            ids_noted++;
        endfunction

        // Compares one received character beat with the oldest expected one.
        function void check_char(input logic [CHAR_W-1:0] code, input logic fin);
            char_beat_t want;
            chars_checked++;
            if (awaited_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("ERROR: unexpected character 0x%02h last=%0b", code, fin);
                end
                return;
            end
            want = awaited_chars.pop_front();
            if (code !== want.code || fin !== want.fin)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("ERROR: character beat %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             chars_checked, want.code, want.fin, code, fin);
                end
            end
        endfunction

        function int outstanding();
            return awaited_chars.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               value_valid;
    logic               value_stall;
    logic [VALUE_W-1:0] value;
    logic               char_valid;
    logic               char_stall;
    logic [CHAR_W-1:0]  character;
    logic               last;

    uid_text_scoreboard board = new();
    bit                 hold_request;
    bit                 quiet;

    // Boundaries of every text length, alphabet edges and bit patterns.
    logic [VALUE_W-1:0] corner_values[24] = '{
        32'd0, 32'd1, 32'd8, 32'd9, 32'd32, 32'd33, 32'd34, 32'd57, 32'd58, 32'd59,
        32'd3363, 32'd3364, 32'd195111, 32'd195112, 32'd11316495, 32'd11316496,
        32'd656356767, 32'd656356768, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000,
        32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF
    };

    base58_uid_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .character   (character),
        .last        (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random identifier over text lengths one to six; a third of picks are full-range, so six comes up most.
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 8);
        case (pick)
            0: return $urandom_range(57, 0);
            1: return $urandom_range(3363, 58);
            2: return $urandom_range(195111, 3364);
            3: return $urandom_range(11316495, 195112);
            4: return $urandom_range(656356767, 11316496);
            5: return $urandom_range(32'hFFFFFFFF, 656356768);
            default: return $urandom();
        endcase
    endfunction

    // Offers one identifier after a random gap and waits for the beat to be taken.
    task automatic send_value(input logic [VALUE_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_valid <= 1'b1;
        value       <= id;
        do
        begin
            @(posedge clk);
        end
        while (value_stall !== 1'b0);
        board.note_value(id);
    endtask

    // Stops offering and waits until every owed character has arrived.
    task automatic drain_results();
        value_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (board.outstanding() != 0);
    endtask

    // Output side: checks each taken beat and stalls at random, once for a long stretch.
    initial
    begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        char_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (char_valid === 1'b1 && char_stall === 1'b0)
            begin
                board.check_char(character, last);
            end
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                char_stall <= 1'b1;
            end
            else
            begin
                char_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any beat.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((value_valid === 1'b1 && value_stall === 1'b0) ||
                (char_valid === 1'b1 && char_stall === 1'b0))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("ERROR: no beat for %0d cycles, %0d characters still owed",
                 IDLE_LIMIT, board.outstanding());
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, directed corners, then random identifiers with pressure phases.
    initial
    begin
        int n;
        hold_request = 1'b0;
        quiet        = 1'b0;
        rst_n       <= 1'b0;
        value_valid <= 1'b0;
        value       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
        begin
            send_value(corner_values[i]);
        end

        for (n = 0; n < NUM_RANDOM; n++)
        begin
            // Long output hold while input keeps coming, so the encoder backs up.
            if (n == 100)
            begin
                hold_request = 1'b1;
            end
            // A stretch with no idling on either side.
            quiet = (n >= 150 && n < 190);
            // Input pause until the encoder is empty.
            if (n == 220)
            begin
                drain_results();
            end
            send_value(random_value());
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("Encoded %0d identifiers and checked %0d characters.",
                 board.ids_noted, board.chars_checked);
        $display("Identifiers by text length 1..6: %0d %0d %0d %0d %0d %0d",
                 board.len_count[1], board.len_count[2], board.len_count[3],
                 board.len_count[4], board.len_count[5], board.len_count[6]);
        if (board.mismatches == 0 && board.outstanding() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("ERROR: %0d mismatches, %0d characters never arrived",
                     board.mismatches, board.outstanding());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
